// ----- rtl/lgmc_pkg.sv -----
// Package for the line grep match counter: constants, register codes, widths.
package lgmc_pkg;

    localparam int MAX_PATTERN_DEF = 16;
    localparam int COUNT_BITS_DEF  = 32;

    localparam int BYTE_W     = 8;
    localparam int REG_BYTES  = 16;
    localparam int LEN_W      = 5;
    localparam int CFG_DATA_W = 64;
    localparam int CFG_IDX_W  = 2;
    localparam int OUT_CNT_W  = 32;

    localparam logic [BYTE_W-1:0] NEWLINE_BYTE = 8'd10;

    typedef logic [BYTE_W-1:0]     byte_t;
    typedef logic [LEN_W-1:0]      len_t;
    typedef logic [CFG_DATA_W-1:0] cfg_data_t;
    typedef logic [OUT_CNT_W-1:0]  out_cnt_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_PATTERN_LOW    = 2'd0,
        CFG_PATTERN_HIGH   = 2'd1,
        CFG_PATTERN_LENGTH = 2'd2
    } cfg_reg_t;

endpackage

// ----- rtl/lgmc_channels.sv -----
// Valid/ready channel interfaces for config, text input and line results.
interface lgmc_cfg_if
    import lgmc_pkg::*;
();
    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    cfg_data_t            data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

interface lgmc_text_if
    import lgmc_pkg::*;
();
    logic  valid;
    logic  ready;
    byte_t text_byte;
    logic  text_end;

    modport source (output valid, output text_byte, output text_end, input ready);
    modport sink   (input valid, input text_byte, input text_end, output ready);
endinterface

interface lgmc_result_if
    import lgmc_pkg::*;
();
    logic     valid;
    logic     ready;
    out_cnt_t line_index;
    logic     line_has_match;
    out_cnt_t matching_lines;
    logic     final_line;

    modport source (output valid, output line_index, output line_has_match,
                    output matching_lines, output final_line, input ready);
    modport sink   (input valid, input line_index, input line_has_match,
                    input matching_lines, input final_line, output ready);
endinterface

// ----- rtl/line_grep_match_counter.sv -----
// Top level: streaming per-line substring match with line and match counters.
// Throughput: 1 byte per cycle, except that a line end stalls while the result
// register holds an untaken result; input register, then one pass of window
// compare and counter update into the result register.
// Reset (rst_n low, async): pipeline empty, window, line and match counts zero,
// pattern registers zero (empty pattern).
module line_grep_match_counter
    import lgmc_pkg::*;
#(
    parameter int MAX_PATTERN = MAX_PATTERN_DEF,
    parameter int COUNT_BITS  = COUNT_BITS_DEF
)
(
    input  logic          clk,
    input  logic          rst_n,
    lgmc_cfg_if.sink      cfg,
    lgmc_text_if.sink     text,
    lgmc_result_if.source result
);

    localparam int BIL_W     = $clog2(MAX_PATTERN + 1);
    localparam int CMP_W     = (BIL_W > LEN_W) ? BIL_W : LEN_W;
    localparam int LEN_LIMIT = (MAX_PATTERN < REG_BYTES) ? MAX_PATTERN : REG_BYTES;

    // config registers
    cfg_data_t pat_low_reg;
    cfg_data_t pat_high_reg;
    len_t      pat_len_reg;

    // input stage
    logic  s1_valid_reg;
    byte_t s1_byte_reg;
    logic  s1_end_reg;

    // line state
    byte_t                 win_reg [MAX_PATTERN];
    byte_t                 win_next [MAX_PATTERN];
    logic [BIL_W-1:0]      bil_reg;
    logic [BIL_W-1:0]      bil_next;
    logic                  match_reg;
    logic                  match_next;
    logic [COUNT_BITS-1:0] lines_reg;
    logic [COUNT_BITS-1:0] lines_next;
    logic [COUNT_BITS-1:0] matches_reg;
    logic [COUNT_BITS-1:0] matches_next;

    // output stage
    logic     out_valid_reg;
    out_cnt_t out_line_reg;
    logic     out_hit_reg;
    out_cnt_t out_matches_reg;
    logic     out_final_reg;

    byte_t                 pat [REG_BYTES];
    len_t                  len_eff;
    logic                  is_nl;
    logic                  emit;
    logic                  hit;
    logic                  cmp_hit;
    logic [MAX_PATTERN-1:0] byte_ok;
    logic [COUNT_BITS-1:0] lines_inc;
    logic [COUNT_BITS-1:0] matches_inc;
    out_cnt_t              lines_cap;
    out_cnt_t              matches_cap;
    logic                  out_free;
    logic                  s1_go;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pat_low_reg  <= '0;
            pat_high_reg <= '0;
            pat_len_reg  <= '0;
        end
        else if (cfg.valid)
        begin
            unique case (cfg.index)
                CFG_PATTERN_LOW:    pat_low_reg  <= cfg.data;
                CFG_PATTERN_HIGH:   pat_high_reg <= cfg.data;
                CFG_PATTERN_LENGTH: pat_len_reg  <= cfg.data[LEN_W-1:0];
                default:            ;
            endcase
        end
    end

    always_comb
    begin
        for (int k = 0; k < REG_BYTES / 2; k++)
        begin
            pat[k]                 = pat_low_reg[k*BYTE_W +: BYTE_W];
            pat[k + REG_BYTES / 2] = pat_high_reg[k*BYTE_W +: BYTE_W];
        end
    end

    assign len_eff = (pat_len_reg > LEN_W'(LEN_LIMIT)) ? LEN_W'(LEN_LIMIT) : pat_len_reg;

    assign out_free   = !out_valid_reg || result.ready;
    assign is_nl      = (s1_byte_reg == NEWLINE_BYTE);
    assign emit       = is_nl || s1_end_reg;
    assign s1_go      = s1_valid_reg && (!emit || out_free);
    assign text.ready = !s1_valid_reg || s1_go;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (text.ready)
        begin
            s1_valid_reg <= text.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (text.ready && text.valid)
        begin
            s1_byte_reg <= text.text_byte;
            s1_end_reg  <= text.text_end;
        end
    end

    // window shift and compare, newest byte at position 0
    always_comb
    begin
        win_next[0] = s1_byte_reg;
        for (int i = 1; i < MAX_PATTERN; i++)
        begin
            win_next[i] = win_reg[i-1];
        end
    end

    assign bil_next = (bil_reg == BIL_W'(MAX_PATTERN)) ? bil_reg : bil_reg + 1'b1;

    always_comb
    begin
        logic [LEN_W-1:0] pidx;
        byte_ok = '1;
        for (int j = 0; j < LEN_LIMIT; j++)
        begin
            pidx       = len_eff - LEN_W'(j) - LEN_W'(1);
            byte_ok[j] = (LEN_W'(j) >= len_eff) || (win_next[j] == pat[pidx[3:0]]);
        end
    end

    assign cmp_hit    = (len_eff != '0) && (CMP_W'(bil_next) >= CMP_W'(len_eff)) && (&byte_ok);
    assign match_next = match_reg || (!is_nl && cmp_hit);
    assign hit        = match_next || (len_eff == '0);

    assign lines_inc   = (&lines_reg) ? lines_reg : lines_reg + 1'b1;
    assign matches_inc = (hit && !(&matches_reg)) ? matches_reg + 1'b1 : matches_reg;

    always_comb
    begin
        lines_next   = lines_reg;
        matches_next = matches_reg;
        if (emit)
        begin
            lines_next   = s1_end_reg ? '0 : lines_inc;
            matches_next = s1_end_reg ? '0 : matches_inc;
        end
    end

    generate
        if (COUNT_BITS > OUT_CNT_W)
        begin : g_cap
            assign lines_cap   = (|lines_inc[COUNT_BITS-1:OUT_CNT_W]) ? '1
                                 : lines_inc[OUT_CNT_W-1:0];
            assign matches_cap = (|matches_inc[COUNT_BITS-1:OUT_CNT_W]) ? '1
                                 : matches_inc[OUT_CNT_W-1:0];
        end
        else
        begin : g_ext
            assign lines_cap   = OUT_CNT_W'(lines_inc);
            assign matches_cap = OUT_CNT_W'(matches_inc);
        end
    endgenerate

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < MAX_PATTERN; i++)
            begin
                win_reg[i] <= '0;
            end
            bil_reg     <= '0;
            match_reg   <= 1'b0;
            lines_reg   <= '0;
            matches_reg <= '0;
        end
        else if (s1_go)
        begin
            if (!is_nl)
            begin
                win_reg <= win_next;
            end
            if (emit)
            begin
                bil_reg   <= '0;
                match_reg <= 1'b0;
            end
            else
            begin
                bil_reg   <= bil_next;
                match_reg <= match_next;
            end
            lines_reg   <= lines_next;
            matches_reg <= matches_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (s1_go && emit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (result.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_go && emit)
        begin
            out_line_reg    <= lines_cap;
            out_hit_reg     <= hit;
            out_matches_reg <= matches_cap;
            out_final_reg   <= s1_end_reg;
        end
    end

    assign result.valid          = out_valid_reg;
    assign result.line_index     = out_line_reg;
    assign result.line_has_match = out_hit_reg;
    assign result.matching_lines = out_matches_reg;
    assign result.final_line     = out_final_reg;

endmodule

// ----- test/tb_top.sv -----
// Testbench for line_grep_match_counter: directed and random texts against a line-match predictor.
`timescale 1ns / 100ps

module tb_top;
    import lgmc_pkg::*;

    localparam int WIN             = MAX_PATTERN_DEF;
    localparam int RESULT_LATENCY  = 2;
    localparam int SETTLE_CYCLES   = RESULT_LATENCY + 4;
    localparam int HOLD_OFF_CYCLES = 300;
    localparam int CYCLE_LIMIT     = 200000;
    localparam int PHASE_ITEMS     = 65;

    typedef struct {
        out_cnt_t line_index;
        logic     has_match;
        out_cnt_t matching_lines;
        logic     final_line;
    } line_result_t;

    logic clk;
    logic rst_n;

    lgmc_cfg_if    cfg_ch();
    lgmc_text_if   text_ch();
    lgmc_result_if res_ch();

    line_grep_match_counter dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .cfg    (cfg_ch),
        .text   (text_ch),
        .result (res_ch)
    );

    // predictor state and pattern registers
    byte_t       window [WIN] = '{default: '0};
    int unsigned line_bytes   = 0;
    bit          line_hit     = 1'b0;
    out_cnt_t    lines_seen   = '0;
    out_cnt_t    hits_seen    = '0;
    cfg_data_t   pat_low      = '0;
    cfg_data_t   pat_high     = '0;
    len_t        pat_len      = '0;

    line_result_t pending_lines [$];
    int unsigned  mismatch_count = 0;
    int unsigned  items_sent     = 0;
    int unsigned  cycle_count    = 0;
    bit           no_gaps        = 1'b0;
    bit           hold_req       = 1'b0;
    int           hold_left      = 0;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic int unsigned used_length();
        int unsigned n;
        n = pat_len;
        if (n > WIN)
            n = WIN;
        if (n > REG_BYTES)
            n = REG_BYTES;
        return n;
    endfunction

    function automatic byte_t pattern_at(int unsigned k);
        logic [2*CFG_DATA_W-1:0] p;
        p = {pat_high, pat_low};
        return p[8*k +: 8];
    endfunction

    task automatic predict_line_result(byte_t b, logic is_last);
        int unsigned  n;
        bit           same;
        line_result_t r;
        n = used_length();
        if (b != NEWLINE_BYTE)
        begin
            for (int i = WIN - 1; i > 0; i--)
                window[i] = window[i-1];
            window[0] = b;
            if (line_bytes < WIN)
                line_bytes++;
            if (n > 0 && line_bytes >= n)
            begin
                same = 1'b1;
                for (int i = 0; i < n; i++)
                    if (window[n-1-i] != pattern_at(i))
                        same = 1'b0;
                if (same)
                    line_hit = 1'b1;
            end
        end
        if (b == NEWLINE_BYTE || is_last)
        begin
            r.has_match = line_hit || n == 0;
            if (lines_seen != '1)
                lines_seen++;
            if (r.has_match && hits_seen != '1)
                hits_seen++;
            r.line_index     = lines_seen;
            r.matching_lines = hits_seen;
            r.final_line     = is_last;
            pending_lines.push_back(r);
            line_bytes = 0;
            line_hit   = 1'b0;
            if (is_last)
            begin
                lines_seen = '0;
                hits_seen  = '0;
            end
        end
    endtask

    task automatic write_reg(cfg_reg_t r, cfg_data_t d);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= r;
        cfg_ch.data  <= d;
        do @(posedge clk); while (!cfg_ch.ready);
        case (r)
            CFG_PATTERN_LOW:    pat_low  = d;
            CFG_PATTERN_HIGH:   pat_high = d;
            CFG_PATTERN_LENGTH: pat_len  = d[LEN_W-1:0];
            default: ;
        endcase
        @(negedge clk);
    endtask

    task automatic set_pattern(cfg_data_t lo, cfg_data_t hi, len_t n);
        cfg_data_t len_word;
        len_word = {$urandom, $urandom};
        len_word[LEN_W-1:0] = n;
        write_reg(CFG_PATTERN_LOW, lo);
        write_reg(CFG_PATTERN_HIGH, hi);
        write_reg(CFG_PATTERN_LENGTH, len_word);
        cfg_ch.valid <= 1'b0;
    endtask

    // one text request; called and returns at a falling edge
    task automatic send_text(byte_t b, logic is_last);
        if (!no_gaps)
            while ($urandom_range(99) < 15)
            begin
                text_ch.valid <= 1'b0;
                @(negedge clk);
            end
        text_ch.valid     <= 1'b1;
        text_ch.text_byte <= b;
        text_ch.text_end  <= is_last;
        do @(posedge clk); while (!text_ch.ready);
        predict_line_result(b, is_last);
        items_sent++;
        @(negedge clk);
    endtask

    task automatic send_str(string s, bit with_nl, bit is_last);
        for (int i = 0; i < s.len(); i++)
            send_text(byte_t'(s[i]), is_last && !with_nl && i == s.len() - 1);
        if (with_nl)
            send_text(NEWLINE_BYTE, is_last);
    endtask

    function automatic byte_t pick_text_byte(int unsigned n);
        int unsigned r;
        r = $urandom_range(9);
        if (r < 6 && n > 0)
            return pattern_at($urandom_range(n - 1));
        if (r < 8)
            return 8'h61 + byte_t'($urandom_range(2));
        return byte_t'($urandom_range(255));
    endfunction

    task automatic send_random_line(int unsigned max_len, bit is_last);
        byte_t       bytes [$];
        int unsigned n;
        int unsigned pos;
        bit          open_end;
        n = used_length();
        repeat ($urandom_range(max_len))
            bytes.push_back(pick_text_byte(n));
        if (n > 0 && $urandom_range(1))
        begin
            pos = $urandom_range(bytes.size());
            for (int k = n - 1; k >= 0; k--)
                bytes.insert(pos, pattern_at(k));
        end
        open_end = is_last && bytes.size() > 0 && $urandom_range(1);
        foreach (bytes[i])
            send_text(bytes[i], open_end && i == bytes.size() - 1);
        if (!open_end)
            send_text(NEWLINE_BYTE, is_last);
    endtask

    task automatic run_text(int unsigned count, int unsigned max_len);
        int unsigned stop_at;
        stop_at = items_sent + count;
        while (items_sent < stop_at)
            if ($urandom_range(19) == 0)
                send_text(byte_t'($urandom_range(255)), $urandom_range(49) == 0);
            else
                send_random_line(max_len, $urandom_range(14) == 0);
        send_random_line(max_len, 1'b1);
    endtask

    task automatic settle();
        text_ch.valid <= 1'b0;
        while (pending_lines.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic test_empty_pattern();
        send_str("ab", 1'b1, 1'b0);
        send_str("", 1'b1, 1'b0);
        send_str("z", 1'b0, 1'b1);
        settle();
    endtask

    task automatic test_zero_and_max_bytes();
        set_pattern(64'h0000_0000_0000_FF00, '0, len_t'(2));
        send_text(8'h00, 1'b0);
        send_text(8'hFF, 1'b0);
        send_str("", 1'b1, 1'b0);
        send_text(8'hFF, 1'b0);
        send_text(8'h00, 1'b0);
        send_str("", 1'b1, 1'b0);
        send_str("", 1'b1, 1'b1);
        settle();
    endtask

    // oversized length, full window, match on an unterminated last line
    task automatic test_full_window();
        logic [2*CFG_DATA_W-1:0] p;
        byte_t                   b;
        for (int k = 0; k < REG_BYTES; k++)
        begin
            b = byte_t'($urandom_range(255));
            p[8*k +: 8] = (b == NEWLINE_BYTE) ? b + 8'd1 : b;
        end
        set_pattern(p[CFG_DATA_W-1:0], p[2*CFG_DATA_W-1:CFG_DATA_W], len_t'(31));
        send_text(8'h71, 1'b0);
        for (int k = 0; k < REG_BYTES; k++)
            send_text(pattern_at(k), k == REG_BYTES - 1);
        settle();
    endtask

    task automatic test_random_texts();
        for (int ph = 0; ph < 7; ph++)
        begin
            case (ph)
                0: set_pattern({$urandom, $urandom}, {$urandom, $urandom}, len_t'(1));
                1: set_pattern({$urandom, $urandom}, {$urandom, $urandom},
                               len_t'($urandom_range(4, 2)));
                2: set_pattern('1, '1, len_t'(16));
                3: set_pattern({$urandom, $urandom}, {$urandom, $urandom}, len_t'(0));
                4: set_pattern('0, '0, len_t'(3));
                5: set_pattern({$urandom, $urandom}, {$urandom, $urandom},
                               len_t'($urandom_range(31, 17)));
                default: set_pattern({$urandom, $urandom}, {$urandom, $urandom},
                                     len_t'($urandom_range(15, 5)));
            endcase
            run_text(PHASE_ITEMS, 20);
            settle();
        end
    endtask

    task automatic test_hold_off();
        set_pattern({$urandom, $urandom}, {$urandom, $urandom}, len_t'(1));
        no_gaps  = 1'b1;
        hold_req = 1'b1;
        run_text(120, 3);
        settle();
        no_gaps = 1'b0;
    endtask

    task automatic test_no_idle();
        set_pattern({$urandom, $urandom}, {$urandom, $urandom}, len_t'($urandom_range(3, 1)));
        no_gaps = 1'b1;
        run_text(150, 20);
        settle();
        no_gaps = 1'b0;
    endtask

    // result ready: random idles, long hold-off on request
    always @(negedge clk)
    begin
        if (hold_req)
        begin
            hold_left = HOLD_OFF_CYCLES;
            hold_req  = 1'b0;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            res_ch.ready <= 1'b0;
        end
        else
            res_ch.ready <= no_gaps || ($urandom_range(99) >= 15);
    end

    always @(posedge clk)
    begin
        line_result_t exp_r;
        if (rst_n && res_ch.valid && res_ch.ready)
        begin
            if (pending_lines.size() == 0)
            begin
                $display("%0t: unexpected result, line_index %0d", $time, res_ch.line_index);
                mismatch_count++;
            end
            else
            begin
                exp_r = pending_lines.pop_front();
                if (res_ch.line_index !== exp_r.line_index)
                begin
                    $display("%0t: line_index expected %0d actual %0d",
                             $time, exp_r.line_index, res_ch.line_index);
                    mismatch_count++;
                end
                if (res_ch.line_has_match !== exp_r.has_match)
                begin
                    $display("%0t: line_has_match expected %0b actual %0b",
                             $time, exp_r.has_match, res_ch.line_has_match);
                    mismatch_count++;
                end
                if (res_ch.matching_lines !== exp_r.matching_lines)
                begin
                    $display("%0t: matching_lines expected %0d actual %0d",
                             $time, exp_r.matching_lines, res_ch.matching_lines);
                    mismatch_count++;
                end
                if (res_ch.final_line !== exp_r.final_line)
                begin
                    $display("%0t: final_line expected %0b actual %0b",
                             $time, exp_r.final_line, res_ch.final_line);
                    mismatch_count++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    initial
    begin
        rst_n             = 1'b0;
        cfg_ch.valid      = 1'b0;
        cfg_ch.index      = CFG_PATTERN_LOW;
        cfg_ch.data       = '0;
        text_ch.valid     = 1'b0;
        text_ch.text_byte = '0;
        text_ch.text_end  = 1'b0;
        res_ch.ready      = 1'b0;
        repeat (9) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        test_empty_pattern();
        test_zero_and_max_bytes();
        test_full_window();
        test_random_texts();
        test_hold_off();
        test_no_idle();

        if (mismatch_count == 0 && pending_lines.size() == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

// ----- files.f -----
rtl/lgmc_pkg.sv
rtl/lgmc_channels.sv
rtl/line_grep_match_counter.sv
test/tb_top.sv
